### hw/rtl/dttf_pkg.sv
`timescale 1ns / 1ps
// dttf_pkg: shared types, character codes and power-of-ten table for the decimal text parser
package dttf_pkg;

    localparam int MANT_W  = 60;
    localparam int VALUE_W = 48;

    localparam logic [VALUE_W-1:0] MAG_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] MAG_NEG_MAX = {1'b1, {(VALUE_W-1){1'b0}}};

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
        logic                      had_digits;
    } result_t;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_ZEROS,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_PARSE,
        ST_INIT,
        ST_DIV,
        ST_PUBLISH
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take_char;
        logic div_init;
        logic div_step;
        logic publish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_sts_t;

    // 10^n for n = 0..18, larger codes clamp to 10^18
    function automatic logic [MANT_W-1:0] pow10(input logic [4:0] n);
        logic [MANT_W-1:0] p;
        p = '0;
        case (n)
            5'd0:    p = 60'd1;
            5'd1:    p = 60'd10;
            5'd2:    p = 60'd100;
            5'd3:    p = 60'd1000;
            5'd4:    p = 60'd10000;
            5'd5:    p = 60'd100000;
            5'd6:    p = 60'd1000000;
            5'd7:    p = 60'd10000000;
            5'd8:    p = 60'd100000000;
            5'd9:    p = 60'd1000000000;
            5'd10:   p = 60'd10000000000;
            5'd11:   p = 60'd100000000000;
            5'd12:   p = 60'd1000000000000;
            5'd13:   p = 60'd10000000000000;
            5'd14:   p = 60'd100000000000000;
            5'd15:   p = 60'd1000000000000000;
            5'd16:   p = 60'd10000000000000000;
            5'd17:   p = 60'd100000000000000000;
            default: p = 60'd1000000000000000000;
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/dttf_ctrl.sv
`timescale 1ns / 1ps
// dttf_ctrl: sequencing of character intake, scaling divide and result hand-off
module dttf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    input  logic                char_last,
    output logic                char_ready,
    output dttf_pkg::dp_cmd_t   cmd,
    input  dttf_pkg::dp_sts_t   sts
);

    dttf_pkg::ctl_state_t state_reg;
    dttf_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dttf_pkg::ST_PARSE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dttf_pkg::ST_PARSE:
            begin
                if (char_valid && char_last)
                begin
                    state_next = dttf_pkg::ST_INIT;
                end
            end
            dttf_pkg::ST_INIT:
            begin
                state_next = dttf_pkg::ST_DIV;
            end
            dttf_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = dttf_pkg::ST_PUBLISH;
                end
            end
            dttf_pkg::ST_PUBLISH:
            begin
                if (sts.out_free)
                begin
                    state_next = dttf_pkg::ST_PARSE;
                end
            end
            default:
            begin
                state_next = dttf_pkg::ST_PARSE;
            end
        endcase
    end

    always_comb
    begin
        char_ready    = 1'b0;
        cmd.take_char = 1'b0;
        cmd.div_init  = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.publish   = 1'b0;
        case (state_reg)
            dttf_pkg::ST_PARSE:
            begin
                char_ready    = 1'b1;
                cmd.take_char = char_valid;
            end
            dttf_pkg::ST_INIT:
            begin
                cmd.div_init = 1'b1;
            end
            dttf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            dttf_pkg::ST_PUBLISH:
            begin
                cmd.publish = sts.out_free;
            end
            default:
            begin
                char_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/dttf_datapath.sv
`timescale 1ns / 1ps
// dttf_datapath: parse state, mantissa accumulator, restoring divider and output register
module dttf_datapath #(
    parameter int MAX_DIGITS = 18,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dttf_pkg::char_t     char_data,
    input  dttf_pkg::dp_cmd_t   cmd,
    output dttf_pkg::dp_sts_t   sts,
    output logic                result_valid,
    input  logic                result_ready,
    output dttf_pkg::result_t   result_data
);

    localparam int MW        = dttf_pkg::MANT_W;
    localparam int VW        = dttf_pkg::VALUE_W;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int DIV_STEPS = MW + FRAC_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= dttf_pkg::CH_ZERO) && (c <= dttf_pkg::CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= dttf_pkg::CH_TAB) && (c <= dttf_pkg::CH_CR)) || (c == dttf_pkg::CH_SPACE);
    endfunction

    // parse state
    dttf_pkg::phase_t phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [MW-1:0]    mant_reg, mant_next;
    logic [CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic [CNT_W-1:0] dec_cnt_reg, dec_cnt_next;
    logic             ovf_reg, ovf_next;
    logic             zero_seen_reg, zero_seen_next;

    // divider
    logic [MW-1:0]     dvd_reg, dvd_next;
    logic [MW-1:0]     div_reg, div_next;
    logic [MW-1:0]     rem_reg, rem_next;
    logic [VW-1:0]     quo_reg, quo_next;
    logic              big_reg, big_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // output
    logic               out_valid_reg, out_valid_next;
    dttf_pkg::result_t  out_reg, out_next;

    logic          after_sign;
    logic          gather_int;
    logic          gather_frac;
    logic [7:0]    c;
    logic [MW:0]   rem_shift;
    logic          rem_ge;
    logic          rnd;
    logic [VW-1:0] mag_rnd;
    logic [VW-1:0] limit;
    logic [VW-1:0] mag;
    logic          sat;

    assign c = char_data.ch;

    // character intake
    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mant_next      = mant_reg;
        dig_cnt_next   = dig_cnt_reg;
        dec_cnt_next   = dec_cnt_reg;
        ovf_next       = ovf_reg;
        zero_seen_next = zero_seen_reg;
        after_sign     = 1'b0;
        gather_int     = 1'b0;
        gather_frac    = 1'b0;
        if (cmd.publish)
        begin
            phase_next     = dttf_pkg::PH_SPACE;
            neg_next       = 1'b0;
            mant_next      = '0;
            dig_cnt_next   = '0;
            dec_cnt_next   = '0;
            ovf_next       = 1'b0;
            zero_seen_next = 1'b0;
        end
        else if (cmd.take_char)
        begin
            case (phase_reg)
                dttf_pkg::PH_SPACE:
                begin
                    if (!is_space(c))
                    begin
                        if ((c == dttf_pkg::CH_MINUS) || (c == dttf_pkg::CH_PLUS))
                        begin
                            neg_next   = (c == dttf_pkg::CH_MINUS);
                            phase_next = dttf_pkg::PH_ZEROS;
                        end
                        else
                        begin
                            after_sign = 1'b1;
                        end
                    end
                end
                dttf_pkg::PH_ZEROS:
                begin
                    after_sign = 1'b1;
                end
                dttf_pkg::PH_INT:
                begin
                    if (is_digit(c))
                    begin
                        gather_int = 1'b1;
                    end
                    else if (c == dttf_pkg::CH_DOT)
                    begin
                        phase_next = dttf_pkg::PH_FRAC;
                    end
                    else
                    begin
                        phase_next = dttf_pkg::PH_DONE;
                    end
                end
                dttf_pkg::PH_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        gather_frac = 1'b1;
                    end
                    else
                    begin
                        phase_next = dttf_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = dttf_pkg::PH_DONE;
                end
            endcase

            if (after_sign)
            begin
                if (c == dttf_pkg::CH_ZERO)
                begin
                    zero_seen_next = 1'b1;
                    phase_next     = dttf_pkg::PH_ZEROS;
                end
                else if (is_digit(c))
                begin
                    gather_int = 1'b1;
                    phase_next = dttf_pkg::PH_INT;
                end
                else if (c == dttf_pkg::CH_DOT)
                begin
                    phase_next = dttf_pkg::PH_FRAC;
                end
                else
                begin
                    phase_next = dttf_pkg::PH_DONE;
                end
            end

            if (gather_int || gather_frac)
            begin
                if (dig_cnt_reg < CNT_W'(MAX_DIGITS))
                begin
                    // mantissa * 10 + digit
                    mant_next    = (mant_reg << 3) + (mant_reg << 1)
                                   + MW'(c - dttf_pkg::CH_ZERO);
                    dig_cnt_next = dig_cnt_reg + 1'b1;
                    if (gather_frac)
                    begin
                        dec_cnt_next = dec_cnt_reg + 1'b1;
                    end
                end
                else if (gather_int)
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    // restoring divide of mantissa * 2^FRAC_BITS by 10^decimal_count, one bit per step
    assign rem_shift = {rem_reg, dvd_reg[MW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        big_next  = big_reg;
        step_next = step_reg;
        if (cmd.div_init)
        begin
            dvd_next  = mant_reg;
            div_next  = dttf_pkg::pow10(5'(dec_cnt_reg));
            rem_next  = '0;
            quo_next  = '0;
            big_next  = 1'b0;
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            dvd_next  = dvd_reg << 1;
            rem_next  = rem_ge ? MW'(rem_shift - {1'b0, div_reg}) : MW'(rem_shift);
            quo_next  = {quo_reg[VW-2:0], rem_ge};
            big_next  = big_reg | quo_reg[VW-1];
            step_next = step_reg + 1'b1;
        end
    end

    assign sts.div_last = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || result_ready;

    // rounding, clamping and sign
    assign rnd     = ({rem_reg, 1'b0} >= {1'b0, div_reg});
    assign mag_rnd = quo_reg + VW'(rnd);
    assign limit   = neg_reg ? dttf_pkg::MAG_NEG_MAX : dttf_pkg::MAG_POS_MAX;

    always_comb
    begin
        if (dig_cnt_reg == '0)
        begin
            sat = 1'b0;
            mag = '0;
        end
        else
        begin
            sat = ovf_reg || big_reg || quo_reg[VW-1] || (mag_rnd > limit);
            mag = sat ? limit : mag_rnd;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_next.value      = neg_reg ? -mag : mag;
            out_next.saturated  = sat;
            out_next.had_digits = (dig_cnt_reg != '0) || zero_seen_reg;
            out_valid_next      = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dttf_pkg::PH_SPACE;
            neg_reg       <= 1'b0;
            mant_reg      <= '0;
            dig_cnt_reg   <= '0;
            dec_cnt_reg   <= '0;
            ovf_reg       <= 1'b0;
            zero_seen_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mant_reg      <= mant_next;
            dig_cnt_reg   <= dig_cnt_next;
            dec_cnt_reg   <= dec_cnt_next;
            ovf_reg       <= ovf_next;
            zero_seen_reg <= zero_seen_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        big_reg <= big_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

### hw/rtl/decimal_text_to_fixed.sv
`timescale 1ns / 1ps
// decimal_text_to_fixed: streaming decimal string parser giving signed fixed point
//
//  channel  | signals                                  | request
//  ---------+------------------------------------------+---------------------------------
//  char     | char_valid, char_ready, char_data        | one character, last flag on end
//  result   | result_valid, result_ready, result_data  | value, saturated, had_digits
//
// characters that are not last are taken back to back while char_ready is high
// a last character goes through intake, divider load, one restoring divide step per quotient
//   bit, then rounding and hand-off
// the result sits in an output register; parsing of the next string starts while it waits
// char_ready is low from divider load through hand-off; hand-off waits for a free output
// rst_n is asynchronous and returns the parser to whitespace skipping with no result pending
module decimal_text_to_fixed #(
    parameter int MAX_DIGITS = 18,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_ready,
    input  dttf_pkg::char_t    char_data,
    output logic               result_valid,
    input  logic               result_ready,
    output dttf_pkg::result_t  result_data
);

    // command and status between sequencer and datapath
    dttf_pkg::dp_cmd_t cmd;
    dttf_pkg::dp_sts_t sts;

    // sequencer: parse, load divider, divide, publish
    dttf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_last  (char_data.last),
        .char_ready (char_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // parse registers, mantissa, divider and output register
    dttf_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_data    (char_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

### tb/dttf_result_checker.sv
`timescale 1ns / 1ps
// dttf_result_checker: predicts parsed numbers from accepted characters and checks the results
module dttf_result_checker #(
    parameter int MAX_DIGITS = 18,
    parameter int FRAC_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    input  logic              char_ready,
    input  dttf_pkg::char_t   char_data,
    input  logic              result_valid,
    input  logic              result_ready,
    input  dttf_pkg::result_t result_data,
    output int                errors,
    output int                pending,
    output int                checked
);

    localparam int REPORT_MAX = 10;

    // parser state as seen from the accepted characters
    dttf_pkg::phase_t cur_phase;
    logic             neg;
    logic [63:0]      mant;
    int               digit_total;
    int               n_frac;
    logic             int_overflow;
    logic             zero_seen;

    dttf_pkg::result_t expected_numbers[$];
    dttf_pkg::result_t want;
    logic              bad;
    int                mismatch_count;
    int                result_count;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= dttf_pkg::CH_ZERO && c <= dttf_pkg::CH_NINE;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c >= dttf_pkg::CH_TAB && c <= dttf_pkg::CH_CR) || c == dttf_pkg::CH_SPACE;
    endfunction

    task automatic clear_number();
        cur_phase    = dttf_pkg::PH_SPACE;
        neg          = 1'b0;
        mant         = '0;
        digit_total  = 0;
        n_frac       = 0;
        int_overflow = 1'b0;
        zero_seen    = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] c, input logic frac);
        if (digit_total < MAX_DIGITS)
        begin
            mant = mant * 64'd10 + 64'(c - dttf_pkg::CH_ZERO);
            digit_total++;
            if (frac)
                n_frac++;
        end
        else if (!frac)
        begin
            int_overflow = 1'b1;
        end
    endtask

    // shared by the whitespace and leading-zero phases
    task automatic after_sign(input logic [7:0] c);
        if (c == dttf_pkg::CH_ZERO)
        begin
            zero_seen = 1'b1;
            cur_phase = dttf_pkg::PH_ZEROS;
        end
        else if (is_digit(c))
        begin
            take_digit(c, 1'b0);
            cur_phase = dttf_pkg::PH_INT;
        end
        else if (c == dttf_pkg::CH_DOT)
        begin
            cur_phase = dttf_pkg::PH_FRAC;
        end
        else
        begin
            cur_phase = dttf_pkg::PH_DONE;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        case (cur_phase)
            dttf_pkg::PH_SPACE:
            begin
                if (!is_blank(c))
                begin
                    if (c == dttf_pkg::CH_MINUS || c == dttf_pkg::CH_PLUS)
                    begin
                        neg       = (c == dttf_pkg::CH_MINUS);
                        cur_phase = dttf_pkg::PH_ZEROS;
                    end
                    else
                    begin
                        after_sign(c);
                    end
                end
            end
            dttf_pkg::PH_ZEROS:
                after_sign(c);
            dttf_pkg::PH_INT:
            begin
                if (is_digit(c))
                    take_digit(c, 1'b0);
                else if (c == dttf_pkg::CH_DOT)
                    cur_phase = dttf_pkg::PH_FRAC;
                else
                    cur_phase = dttf_pkg::PH_DONE;
            end
            dttf_pkg::PH_FRAC:
            begin
                if (is_digit(c))
                    take_digit(c, 1'b1);
                else
                    cur_phase = dttf_pkg::PH_DONE;
            end
            default:
                cur_phase = dttf_pkg::PH_DONE;
        endcase
    endtask

    // mantissa / 10^n_frac in fixed point, ties rounded away from zero
    function automatic dttf_pkg::result_t finish_number();
        logic [63:0]       lim;
        logic [63:0]       mag;
        logic [63:0]       p;
        logic [63:0]       q;
        logic [63:0]       r;
        logic              sat;
        dttf_pkg::result_t res;
        lim = neg ? 64'(dttf_pkg::MAG_NEG_MAX) : 64'(dttf_pkg::MAG_POS_MAX);
        mag = '0;
        sat = 1'b0;
        if (digit_total != 0)
        begin
            if (int_overflow)
            begin
                sat = 1'b1;
            end
            else
            begin
                p = 64'd1;
                for (int k = 0; k < n_frac; k++)
                    p = p * 64'd10;
                q = mant / p;
                r = mant % p;
                if (q >= (64'd1 << (dttf_pkg::VALUE_W - 1 - FRAC_BITS)))
                begin
                    sat = 1'b1;
                end
                else
                begin
                    mag = q;
                    for (int k = 0; k < FRAC_BITS; k++)
                    begin
                        r   = r << 1;
                        mag = mag << 1;
                        if (r >= p)
                        begin
                            r      = r - p;
                            mag[0] = 1'b1;
                        end
                    end
                    if ((r << 1) >= p)
                        mag = mag + 64'd1;
                    if (mag > lim)
                        sat = 1'b1;
                end
            end
            if (sat)
                mag = lim;
        end
        res.value      = dttf_pkg::VALUE_W'(neg ? 64'd0 - mag : mag);
        res.saturated  = sat;
        res.had_digits = (digit_total != 0) || zero_seen;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_number();
            expected_numbers.delete();
            mismatch_count = 0;
            result_count   = 0;
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            // results first: a result never belongs to a character taken at the same edge
            if (result_valid && result_ready)
            begin
                result_count++;
                if (expected_numbers.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: value=%0d saturated=%0b had_digits=%0b",
                                 result_data.value, result_data.saturated,
                                 result_data.had_digits);
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    bad  = (result_data.value !== want.value)
                        || (result_data.saturated !== want.saturated)
                        || (result_data.had_digits !== want.had_digits);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"mismatch: expected value=%0d saturated=%0b had_digits=%0b,",
                                      " got value=%0d saturated=%0b had_digits=%0b"},
                                     want.value, want.saturated, want.had_digits,
                                     result_data.value, result_data.saturated,
                                     result_data.had_digits);
                    end
                end
            end
            if (char_valid && char_ready)
            begin
                parse_char(char_data.ch);
                if (char_data.last)
                begin
                    expected_numbers.push_back(finish_number());
                    clear_number();
                end
            end
            errors  <= mismatch_count;
            pending <= expected_numbers.size();
            checked <= result_count;
        end
    end

endmodule

### tb/tb_decimal_text_to_fixed.sv
`timescale 1ns / 1ps
// tb_decimal_text_to_fixed: feeds number strings to the parser under random flow control
module tb_decimal_text_to_fixed;

    localparam int MAX_DIGITS   = 18;
    localparam int FRAC_BITS    = 16;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    // longest correct silence: the long receiver hold-off plus one divide, taken several times
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    // a last character still needs its divide and hand-off after it is taken
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_CHARS = 1000;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TOP = 8'hFF;

    logic              clk;
    logic              rst_n;
    logic              char_valid;
    logic              char_ready;
    dttf_pkg::char_t   char_data;
    logic              result_valid;
    logic              result_ready;
    dttf_pkg::result_t result_data;

    int errors;
    int pending;
    int checked;

    // stimulus bookkeeping
    logic [7:0] text_buf[$];
    int         n_chars;
    int         n_strings;
    bit         idle_on;
    bit         long_hold_pending;
    int         quiet;
    int         base;

    decimal_text_to_fixed #(
        .MAX_DIGITS(MAX_DIGITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data (result_data)
    );

    // watches both channels, predicts every number and counts mismatches
    dttf_result_checker #(
        .MAX_DIGITS(MAX_DIGITS),
        .FRAC_BITS (FRAC_BITS)
    ) number_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data (result_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // one character request; valid stays up until the parser takes it
    task automatic send_char(input logic [7:0] c, input logic is_last);
        // optional sender gap before this request
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= {c, is_last};
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        n_chars++;
    endtask

    // sends text_buf as one string, last flag on its final character
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        n_strings++;
    endtask

    task automatic load_str(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic send_str(input string s);
        load_str(s);
        send_text();
    endtask

    // drop valid and hold off until every predicted result has come back
    task automatic pause_sender();
        char_valid <= 1'b0;
        // let the checker count the final request before waiting on pending
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] random_digit();
        return 8'(dttf_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    // any of tab, line feed, vertical tab, form feed, carriage return or space
    function automatic logic [7:0] random_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? dttf_pkg::CH_SPACE : 8'(dttf_pkg::CH_TAB + r);
    endfunction

    // mostly short digit runs, some around the integer range, some past the digit limit
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 5);
        if (r < 8)
            return $urandom_range(6, 11);
        return $urandom_range(15, 22);
    endfunction

    // fills text_buf with a random string: mostly well-formed numbers, some noise
    task automatic build_random_text();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        text_buf.delete();
        if (kind == 0)
        begin
            // pure noise, any byte
            n = $urandom_range(1, 6);
            repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(random_blank());
            n = $urandom_range(0, 3);
            if (n == 0)
                text_buf.push_back(dttf_pkg::CH_MINUS);
            else if (n == 1)
                text_buf.push_back(dttf_pkg::CH_PLUS);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(dttf_pkg::CH_ZERO);
            n = pick_len();
            repeat (n) text_buf.push_back(random_digit());
            if ($urandom_range(0, 4) != 0)
            begin
                text_buf.push_back(dttf_pkg::CH_DOT);
                n = pick_len();
                repeat (n) text_buf.push_back(random_digit());
            end
            // trailing junk that should be ignored
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
            if (text_buf.size() == 0)
                text_buf.push_back(random_digit());
            // broken number: one byte replaced somewhere
            if (kind == 1)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        stall        = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8);
            end
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // watchdog: any edge without a request on either channel counts toward the limit
    initial
    begin
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((char_valid && char_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, pending);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        char_valid        = 1'b0;
        char_data         = '0;
        idle_on           = 1'b1;
        long_hold_pending = 1'b0;
        n_chars           = 0;
        n_strings         = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings
        send_str("x");                       // no digits at all
        send_str(" \t-00");                  // whitespace, negative zero, only zeros
        send_str("+-1");                     // second sign stops parsing
        send_str("- 1");                     // whitespace after the sign stops parsing
        send_str("12e5");                    // stray letter ends the number
        load_str("5");                       // nul byte ends the number
        text_buf.push_back(CH_NUL);
        send_text();
        load_str(".5");                      // fraction only, top byte as junk
        text_buf.push_back(CH_TOP);
        send_text();
        send_str("9999999999999999999");     // integer digit past the limit saturates
        send_str("-.1234567890123456789");   // fraction digits past the limit dropped
        send_str("-2147483648");             // most negative value, reached with the saturated flag set
        send_str("2147483648");              // just above the positive range
        send_str("2147483647.99999999");     // rounding pushes it out of range
        send_str("0.00000762939453125");     // exact tie, rounds away from zero
        pause_sender();

        // random part, first with idling and one long receiver hold-off
        base              = n_chars;
        idle_on           = 1'b1;
        long_hold_pending = 1'b1;
        while (n_chars - base < 400)
        begin
            build_random_text();
            send_text();
        end
        pause_sender();

        // idling switched on and off in stretches
        while (n_chars - base < 850)
        begin
            if ($urandom_range(0, 7) == 0)
                idle_on = ~idle_on;
            build_random_text();
            send_text();
        end

        // full rate at the end
        idle_on = 1'b0;
        while (n_chars - base < RANDOM_CHARS)
        begin
            build_random_text();
            send_text();
        end
        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d strings in %0d characters, %0d parsed numbers checked",
                 n_strings, n_chars, checked);
        $display("run: signs, blanks, noise, digit limits, range clamps, stalls and drains");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
